/* design/scp_pkg.sv */
package scp_pkg;

    localparam int ADDR_W = 5;
    localparam int NUM_REGS = 6;

    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] plane_x;
        logic signed [31:0] plane_y;
    } cfg_t;

endpackage

/* design/scp_cfg.sv */
module scp_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [scp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output scp_pkg::cfg_t              cfg
);

    scp_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr) begin
            case (idx)
                scp_pkg::REG_POS_X:   cfg_reg.pos_x   <= pwdata;
                scp_pkg::REG_POS_Y:   cfg_reg.pos_y   <= pwdata;
                scp_pkg::REG_DIR_X:   cfg_reg.dir_x   <= pwdata;
                scp_pkg::REG_DIR_Y:   cfg_reg.dir_y   <= pwdata;
                scp_pkg::REG_PLANE_X: cfg_reg.plane_x <= pwdata;
                scp_pkg::REG_PLANE_Y: cfg_reg.plane_y <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            scp_pkg::REG_POS_X:   prdata = cfg_reg.pos_x;
            scp_pkg::REG_POS_Y:   prdata = cfg_reg.pos_y;
            scp_pkg::REG_DIR_X:   prdata = cfg_reg.dir_x;
            scp_pkg::REG_DIR_Y:   prdata = cfg_reg.dir_y;
            scp_pkg::REG_PLANE_X: prdata = cfg_reg.plane_x;
            scp_pkg::REG_PLANE_Y: prdata = cfg_reg.plane_y;
            default:              prdata = '0;
        endcase
    end

endmodule

/* design/scp_divider.sv */
// Restoring divider, one quotient bit per pipeline stage.
// in_rem must be below in_div; in_feed bits are shifted in MSB first.
module scp_divider #(
    parameter int DW    = 64,
    parameter int STEPS = 32,
    parameter int SW    = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_vld,
    input  logic [DW-1:0]    in_div,
    input  logic [DW-1:0]    in_rem,
    input  logic [STEPS-1:0] in_feed,
    input  logic [SW-1:0]    in_side,
    output logic             out_vld,
    output logic [STEPS-1:0] out_quo,
    output logic [SW-1:0]    out_side
);

    logic [STEPS-1:0] vld_reg;
    logic [DW-1:0]    rem_reg  [STEPS];
    logic [DW-1:0]    div_reg  [STEPS];
    logic [STEPS-1:0] feed_reg [STEPS];
    logic [STEPS-1:0] quo_reg  [STEPS];
    logic [SW-1:0]    side_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic [DW-1:0]    rem_p;
        logic [DW-1:0]    div_p;
        logic [STEPS-1:0] feed_p;
        logic [STEPS-1:0] quo_p;
        logic [SW-1:0]    side_p;
        logic             vld_p;
        logic [DW:0]      trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_p  = in_rem;
            assign div_p  = in_div;
            assign feed_p = in_feed;
            assign quo_p  = '0;
            assign side_p = in_side;
            assign vld_p  = in_vld;
        end else begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign div_p  = div_reg[k-1];
            assign feed_p = feed_reg[k-1];
            assign quo_p  = quo_reg[k-1];
            assign side_p = side_reg[k-1];
            assign vld_p  = vld_reg[k-1];
        end

        assign trial = {rem_p, feed_p[STEPS-1]};
        assign ge    = trial >= {1'b0, div_p};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? DW'(trial - {1'b0, div_p}) : trial[DW-1:0];
                div_reg[k]  <= div_p;
                feed_reg[k] <= feed_p << 1;
                quo_reg[k]  <= {quo_p[STEPS-2:0], ge};
                side_reg[k] <= side_p;
            end
        end
    end

    assign out_vld  = vld_reg[STEPS-1];
    assign out_quo  = quo_reg[STEPS-1];
    assign out_side = side_reg[STEPS-1];

endmodule

/* design/sprite_camera_projection.sv */
// Sprite projection through a raycaster camera.
// Camera registers (player position, direction, plane; signed Q16.16) sit on
// the APB port at byte offsets 0x00..0x14; write them only while idle.
// Input channel s_*: one sprite world position per word. Result channel m_*:
// one word per sprite with depth, screen column, projected size, clamped
// draw bounds and a fault bit (zero determinant or zero depth, other fields
// then zero).
// The path from input accept to m_valid runs through a 32-stage divider for
// the camera transform, a 16-stage divider for column and size, plus the
// multiply, setup and saturation stages around them.
// Throughput is one word per cycle while m_ready does not stall it; every stage holds one word.
// When m_ready is low with a result waiting, the whole pipeline freezes and
// s_ready drops; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and the camera
// registers to zero.
module sprite_camera_projection #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [31:0]         s_sprite_x,
    input  logic signed [31:0]         s_sprite_y,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [31:0]         m_depth,
    output logic signed [15:0]         m_screen_col,
    output logic [15:0]                m_proj_size,
    output logic [7:0]                 m_first_row,
    output logic [8:0]                 m_last_row,
    output logic [14:0]                m_first_col,
    output logic signed [15:0]         m_last_col,
    output logic                       m_div_fault,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [scp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int HALF_W = SCREEN_WIDTH / 2;
    localparam int HALF_H = SCREEN_HEIGHT / 2;
    localparam int HW_W   = $clog2(HALF_W + 1);
    localparam int PW     = 33 + HW_W;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_q32(input logic [31:0] q, input logic neg,
                                                   input logic ovf);
        if (neg) begin
            if (ovf || q > 32'h8000_0000) begin
                return 32'sh8000_0000;
            end
            return -$signed(q);
        end
        if (ovf || q > 32'h7fff_ffff) begin
            return 32'sh7fff_ffff;
        end
        return $signed(q);
    endfunction

    scp_pkg::cfg_t cfg;
    logic          en;

    scp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // relative position, determinant products
    logic               v1_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic signed [63:0] p1_reg, p2_reg;

    // camera products
    logic               v2_reg;
    logic signed [63:0] ma_reg, mb_reg, mc_reg, md_reg, det2_reg;

    // numerators
    logic               v3_reg;
    logic signed [63:0] nx3_reg, ny3_reg, det3_reg;

    // magnitudes and signs
    logic               v4_reg;
    logic [63:0]        nx4_reg, ny4_reg, d4_reg;
    logic               negx4_reg, negy4_reg, detz4_reg;

    // divider setup
    logic               v5_reg;
    logic [63:0]        remx5_reg, remy5_reg, d5_reg;
    logic [31:0]        feedx5_reg, feedy5_reg;
    logic               negx5_reg, negy5_reg, ovfx5_reg, ovfy5_reg, detz5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg <= sat33(33'(s_sprite_x) - 33'(cfg.pos_x));
            ry_reg <= sat33(33'(s_sprite_y) - 33'(cfg.pos_y));
            p1_reg <= 64'(cfg.plane_x) * 64'(cfg.dir_y);
            p2_reg <= 64'(cfg.dir_x) * 64'(cfg.plane_y);

            ma_reg   <= 64'(cfg.dir_y) * 64'(rx_reg);
            mb_reg   <= 64'(cfg.dir_x) * 64'(ry_reg);
            mc_reg   <= 64'(cfg.plane_x) * 64'(ry_reg);
            md_reg   <= 64'(cfg.plane_y) * 64'(rx_reg);
            det2_reg <= p1_reg - p2_reg;

            nx3_reg  <= ma_reg - mb_reg;
            ny3_reg  <= mc_reg - md_reg;
            det3_reg <= det2_reg;

            nx4_reg   <= nx3_reg[63] ? 64'(-nx3_reg) : 64'(nx3_reg);
            ny4_reg   <= ny3_reg[63] ? 64'(-ny3_reg) : 64'(ny3_reg);
            d4_reg    <= det3_reg[63] ? 64'(-det3_reg) : 64'(det3_reg);
            negx4_reg <= nx3_reg[63] ^ det3_reg[63];
            negy4_reg <= ny3_reg[63] ^ det3_reg[63];
            detz4_reg <= det3_reg == 64'sd0;

            // quotient of 2^32 or more saturates anyway
            ovfx5_reg  <= {16'h0, nx4_reg[63:16]} >= d4_reg;
            ovfy5_reg  <= {16'h0, ny4_reg[63:16]} >= d4_reg;
            remx5_reg  <= {16'h0, nx4_reg[63:16]};
            remy5_reg  <= {16'h0, ny4_reg[63:16]};
            feedx5_reg <= {nx4_reg[15:0], 16'h0};
            feedy5_reg <= {ny4_reg[15:0], 16'h0};
            d5_reg     <= d4_reg;
            negx5_reg  <= negx4_reg;
            negy5_reg  <= negy4_reg;
            detz5_reg  <= detz4_reg;
        end
    end

    logic        dvx_vld, dvy_vld;
    logic [31:0] qx, qy;
    logic [2:0]  sidex;
    logic [1:0]  sidey;

    scp_divider #(.DW(64), .STEPS(32), .SW(3)) u_div_tx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (v5_reg),
        .in_div   (d5_reg),
        .in_rem   (remx5_reg),
        .in_feed  (feedx5_reg),
        .in_side  ({detz5_reg, negx5_reg, ovfx5_reg}),
        .out_vld  (dvx_vld),
        .out_quo  (qx),
        .out_side (sidex)
    );

    scp_divider #(.DW(64), .STEPS(32), .SW(2)) u_div_ty (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (v5_reg),
        .in_div   (d5_reg),
        .in_rem   (remy5_reg),
        .in_feed  (feedy5_reg),
        .in_side  ({negy5_reg, ovfy5_reg}),
        .out_vld  (dvy_vld),
        .out_quo  (qy),
        .out_side (sidey)
    );

    // saturated tx, ty
    logic               v6_reg;
    logic signed [31:0] tx6_reg, ty6_reg;
    logic               detz6_reg;

    // column numerator, depth magnitude
    logic               v7_reg;
    logic signed [32:0] sum7_reg;
    logic signed [31:0] ty7_reg;
    logic [31:0]        tya7_reg;
    logic               negc7_reg, fault7_reg;

    logic               v8_reg;
    logic [32:0]        suma8_reg;
    logic signed [31:0] ty8_reg;
    logic [31:0]        tya8_reg;
    logic               negc8_reg, fault8_reg;

    logic               v9_reg;
    logic [PW-1:0]      prod9_reg;
    logic signed [31:0] ty9_reg;
    logic [31:0]        tya9_reg;
    logic               negc9_reg, fault9_reg;

    logic               v10_reg;
    logic [31:0]        remc10_reg, tya10_reg;
    logic [15:0]        feedc10_reg;
    logic signed [31:0] ty10_reg;
    logic               negc10_reg, ovfc10_reg, ovfs10_reg, fault10_reg;

    logic [PW+31:0]     prod_ext;

    assign prod_ext = {32'h0, prod9_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (en) begin
            v6_reg  <= dvx_vld && dvy_vld;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tx6_reg   <= sat_q32(qx, sidex[1], sidex[0]);
            ty6_reg   <= sat_q32(qy, sidey[1], sidey[0]);
            detz6_reg <= sidex[2];

            sum7_reg   <= 33'(tx6_reg) + 33'(ty6_reg);
            ty7_reg    <= ty6_reg;
            tya7_reg   <= ty6_reg[31] ? 32'(-ty6_reg) : 32'(ty6_reg);
            negc7_reg  <= (33'(tx6_reg) + 33'(ty6_reg) < 33'sd0) ^ ty6_reg[31];
            fault7_reg <= detz6_reg || ty6_reg == 32'sd0;

            suma8_reg  <= sum7_reg[32] ? 33'(-sum7_reg) : 33'(sum7_reg);
            ty8_reg    <= ty7_reg;
            tya8_reg   <= tya7_reg;
            negc8_reg  <= negc7_reg;
            fault8_reg <= fault7_reg;

            prod9_reg  <= PW'(suma8_reg) * PW'(HALF_W);
            ty9_reg    <= ty8_reg;
            tya9_reg   <= tya8_reg;
            negc9_reg  <= negc8_reg;
            fault9_reg <= fault8_reg;

            // column quotient past 16 bits saturates
            ovfc10_reg  <= prod_ext >= (PW+32)'({tya9_reg, 16'h0});
            remc10_reg  <= prod_ext[47:16];
            feedc10_reg <= prod9_reg[15:0];
            // size: H*2^16/|ty| reaches 2^16 exactly when |ty| <= H
            ovfs10_reg  <= tya9_reg <= 32'(SCREEN_HEIGHT);
            tya10_reg   <= tya9_reg;
            ty10_reg    <= ty9_reg;
            negc10_reg  <= negc9_reg;
            fault10_reg <= fault9_reg;
        end
    end

    logic        dc_vld, ds_vld;
    logic [15:0] qc, qs;
    logic [34:0] sidec;
    logic        sides;

    scp_divider #(.DW(32), .STEPS(16), .SW(35)) u_div_col (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (v10_reg),
        .in_div   (tya10_reg),
        .in_rem   (remc10_reg),
        .in_feed  (feedc10_reg),
        .in_side  ({ty10_reg, negc10_reg, ovfc10_reg, fault10_reg}),
        .out_vld  (dc_vld),
        .out_quo  (qc),
        .out_side (sidec)
    );

    scp_divider #(.DW(32), .STEPS(16), .SW(1)) u_div_size (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (v10_reg),
        .in_div   (tya10_reg),
        .in_rem   (32'(SCREEN_HEIGHT)),
        .in_feed  (16'h0),
        .in_side  (ovfs10_reg),
        .out_vld  (ds_vld),
        .out_quo  (qs),
        .out_side (sides)
    );

    logic               v11_reg;
    logic signed [15:0] col11_reg;
    logic [15:0]        size11_reg;
    logic signed [31:0] ty11_reg;
    logic               fault11_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v11_reg <= 1'b0;
        end else if (en) begin
            v11_reg <= dc_vld && ds_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sidec[2]) begin
                col11_reg <= (sidec[1] || qc > 16'h8000) ? 16'sh8000 : 16'(-$signed({1'b0, qc}));
            end else begin
                col11_reg <= (sidec[1] || qc > 16'h7fff) ? 16'sh7fff : $signed(qc);
            end
            size11_reg  <= sides ? 16'hffff : qs;
            ty11_reg    <= sidec[34:3];
            fault11_reg <= sidec[0];
        end
    end

    // draw bounds
    logic [14:0]        half;
    logic signed [17:0] sr, er, sc, ec;

    assign half = size11_reg[15:1];
    assign sr   = 18'(HALF_H) - 18'(half);
    assign er   = 18'(HALF_H) + 18'(half);
    assign sc   = 18'(col11_reg) - 18'(half);
    assign ec   = 18'(col11_reg) + 18'(half);

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v11_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (fault11_reg) begin
                m_depth      <= '0;
                m_screen_col <= '0;
                m_proj_size  <= '0;
                m_first_row  <= '0;
                m_last_row   <= '0;
                m_first_col  <= '0;
                m_last_col   <= '0;
                m_div_fault  <= 1'b1;
            end else begin
                m_depth      <= ty11_reg;
                m_screen_col <= col11_reg;
                m_proj_size  <= size11_reg;
                m_first_row  <= (sr < 18'sd0) ? 8'd0 : sr[7:0];
                m_last_row   <= (er >= 18'(SCREEN_HEIGHT)) ? 9'(SCREEN_HEIGHT - 1) : er[8:0];
                m_first_col  <= (sc < 18'sd0) ? 15'd0 : sc[14:0];
                m_last_col   <= (ec >= 18'(SCREEN_WIDTH)) ? 16'(SCREEN_WIDTH - 1) : ec[15:0];
                m_div_fault  <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

    a_fault_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_fault |-> m_depth == 32'sd0 && m_proj_size == 16'd0
            && m_screen_col == 16'sd0)
        else $error("fault result carries nonzero fields");

    a_depth_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_div_fault |-> m_depth != 32'sd0)
        else $error("zero depth without fault");

    a_last_col_clamp : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_div_fault |-> $signed(m_last_col) <= 16'(SCREEN_WIDTH - 1))
        else $error("last column past screen edge");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
